>>> rtl/core/ultrasonic_range_sequencer_assert.svh
// Assertion macros for the ultrasonic range sequencer.
// Every macro expects aclk and aresetn to exist in the module that uses it.
`ifndef ULTRASONIC_RANGE_SEQUENCER_ASSERT_SVH
`define ULTRASONIC_RANGE_SEQUENCER_ASSERT_SVH

// Antecedent and consequent checked in the same cycle.
`define RUS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rus_pkg.sv
// Shared constants, codes and types of the ultrasonic range sequencer.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps

package rus_pkg;

    // Timer counter width; the echo count is masked to this many bits.
    localparam int COUNT_WIDTH = 16;

    localparam int OPCODE_W = 3;
    localparam int ECHO_W   = 16;
    localparam int THR_W    = 14;
    localparam int ERR_W    = 2;
    localparam int PHASE_W  = 2;
    localparam int TIME_W   = 16;
    localparam int DIST_W   = 18;
    localparam int CLASS_W  = 2;

    // Bits of the echo count that survive the counter mask.
    localparam int C_W = (COUNT_WIDTH < ECHO_W) ? COUNT_WIDTH : ECHO_W;

    // Event codes.
    localparam logic [OPCODE_W-1:0] OP_ENABLE   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_START    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TRIG_OFF = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_OVERFLOW = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ECHO     = 3'd4;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_STOPPED = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAITING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TRIGGER = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RUNNING = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BUSY    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd2;

    // Proximity classes.
    localparam logic [CLASS_W-1:0] CL_SAFE    = 2'd0;
    localparam logic [CLASS_W-1:0] CL_WARNING = 2'd1;
    localparam logic [CLASS_W-1:0] CL_DANGER  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_WARNING = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DANGER  = 1'd1;

    localparam logic [THR_W-1:0] WARNING_RESET = 14'd400;
    localparam logic [THR_W-1:0] DANGER_RESET  = 14'd200;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Class compare: count * 343 against threshold_mm * 2000.
    localparam int SCALE_NUM   = 343;
    localparam int THR_SCALE   = 2000;
    localparam int THR_SCALED_W = THR_W + 11;
    localparam int CNT_SCALED_W = C_W + 9;
    localparam int CMP_W = (CNT_SCALED_W > THR_SCALED_W) ? CNT_SCALED_W : THR_SCALED_W;

    // Distance in 1/16 mm: count * 343 / 125 = 2 * count + count * 93 / 125.
    // The fractional part uses an exact reciprocal: 93 * count stays below
    // 2^(C_W+7) and the rounding error of the magic number stays below 2^7.
    localparam int DIV_DEN   = 125;
    localparam int FRAC_MUL  = 93;
    localparam int DIV_SHIFT = C_W + 14;
    localparam longint unsigned DIV_MAGIC =
        ((64'd1 << DIV_SHIFT) + longint'(DIV_DEN - 1)) / longint'(DIV_DEN);
    localparam longint unsigned FRAC_K = longint'(FRAC_MUL) * DIV_MAGIC;
    localparam int PROD_W = C_W + DIV_SHIFT;

    // Stream widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int RESULT_W  = 1 + ERR_W + PHASE_W + 1 + TIME_W + DIST_W + CLASS_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    typedef struct packed {
        logic [THR_SCALED_W-1:0] warning_scaled;
        logic [THR_SCALED_W-1:0] danger_scaled;
    } thr_t;

    typedef struct packed {
        logic [TIME_W-1:0]  echo_time;
        logic [DIST_W-1:0]  distance_q4;
        logic [CLASS_W-1:0] proximity;
    } range_t;

    // Declared from the top bit down so that accepted lands in bit 0.
    typedef struct packed {
        logic [CLASS_W-1:0] proximity;
        logic [DIST_W-1:0]  distance_q4;
        logic [TIME_W-1:0]  echo_time;
        logic               trigger_level;
        logic [PHASE_W-1:0] phase;
        logic [ERR_W-1:0]   error_code;
        logic               accepted;
    } result_t;

endpackage

>>> rtl/core/rus_thresholds.sv
// Threshold registers, stored already scaled by 2000 for the class compare.
// Depends on rus_pkg.
`timescale 1ns / 1ps

module rus_thresholds (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rus_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rus_pkg::THR_W-1:0]      cfg_wdata,
    output rus_pkg::thr_t                  thr
);
    import rus_pkg::*;

    logic [THR_SCALED_W-1:0] warning_reg;
    logic [THR_SCALED_W-1:0] danger_reg;
    logic [THR_SCALED_W-1:0] wdata_scaled;

    assign wdata_scaled = THR_SCALED_W'(cfg_wdata) * THR_SCALED_W'(THR_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warning_reg <= THR_SCALED_W'(WARNING_RESET) * THR_SCALED_W'(THR_SCALE);
            danger_reg  <= THR_SCALED_W'(DANGER_RESET) * THR_SCALED_W'(THR_SCALE);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WARNING: warning_reg <= wdata_scaled;
                REG_DANGER:  danger_reg  <= wdata_scaled;
                default:     ;
            endcase
        end
    end

    assign thr.warning_scaled = warning_reg;
    assign thr.danger_scaled  = danger_reg;

endmodule

>>> rtl/core/rus_range_calc.sv
// Echo count to stored time, distance in 1/16 mm and proximity class.
// Depends on rus_pkg. Purely combinational.
`timescale 1ns / 1ps

module rus_range_calc (
    input  logic [rus_pkg::ECHO_W-1:0] echo_count,
    input  rus_pkg::thr_t              thr,
    output rus_pkg::range_t            range
);
    import rus_pkg::*;

    logic [C_W-1:0]    cnt;
    logic [PROD_W-1:0] frac_prod;
    logic [C_W-1:0]    frac_q;
    logic [DIST_W:0]   dist_sum;
    logic [CMP_W-1:0]  cnt_scaled;

    assign cnt = echo_count[C_W-1:0];

    // floor(93 * cnt / 125) by one constant multiply and a shift.
    assign frac_prod = PROD_W'(cnt) * PROD_W'(FRAC_K);
    assign frac_q    = frac_prod[PROD_W-1:DIV_SHIFT];
    assign dist_sum  = ((DIST_W+1)'(cnt) << 1) + (DIST_W+1)'(frac_q);

    assign cnt_scaled = CMP_W'(cnt) * CMP_W'(SCALE_NUM);

    always_comb begin
        range.echo_time   = TIME_W'(cnt);
        range.distance_q4 = (dist_sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX
                                                               : dist_sum[DIST_W-1:0];
        // Danger is tested first, so out-of-order thresholds favor danger.
        if (cnt_scaled <= CMP_W'(thr.danger_scaled)) begin
            range.proximity = CL_DANGER;
        end else if (cnt_scaled <= CMP_W'(thr.warning_scaled)) begin
            range.proximity = CL_WARNING;
        end else begin
            range.proximity = CL_SAFE;
        end
    end

endmodule

>>> rtl/core/rus_phase_fsm.sv
// Phase state machine, measurement state and the result register.
// Depends on rus_pkg.
`timescale 1ns / 1ps

module rus_phase_fsm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [rus_pkg::OPCODE_W-1:0] opcode,
    input  rus_pkg::range_t              range,
    input  logic                         res_taken,
    output logic                         res_valid,
    output rus_pkg::result_t             res
);
    import rus_pkg::*;

    logic [PHASE_W-1:0] phase_reg,    phase_next;
    logic               trigger_reg,  trigger_next;
    logic [TIME_W-1:0]  time_reg,     time_next;
    logic [DIST_W-1:0]  distance_reg, distance_next;
    logic [CLASS_W-1:0] class_reg,    class_next;
    logic [ERR_W-1:0]   err;

    logic    res_valid_reg;
    result_t res_reg, res_next;

    always_comb begin
        phase_next    = phase_reg;
        trigger_next  = trigger_reg;
        time_next     = time_reg;
        distance_next = distance_reg;
        class_next    = class_reg;
        err           = ERR_NONE;
        unique case (opcode)
            OP_ENABLE: begin
                if (phase_reg != PH_STOPPED) begin
                    err = ERR_BUSY;
                end else begin
                    phase_next = PH_WAITING;
                end
            end
            OP_START: begin
                if (phase_reg != PH_WAITING) begin
                    err = ERR_INVALID;
                end else begin
                    phase_next   = PH_TRIGGER;
                    trigger_next = 1'b1;
                end
            end
            OP_TRIG_OFF: begin
                if (phase_reg != PH_TRIGGER) begin
                    err = ERR_INVALID;
                end else begin
                    phase_next   = PH_RUNNING;
                    trigger_next = 1'b0;
                end
            end
            OP_OVERFLOW: begin
                if (phase_reg != PH_RUNNING) begin
                    err = ERR_INVALID;
                end else begin
                    phase_next    = PH_STOPPED;
                    trigger_next  = 1'b0;
                    time_next     = TIME_MAX;
                    distance_next = DIST_MAX;
                end
            end
            OP_ECHO: begin
                if (phase_reg != PH_RUNNING) begin
                    err = ERR_INVALID;
                end else begin
                    phase_next    = PH_STOPPED;
                    trigger_next  = 1'b0;
                    time_next     = range.echo_time;
                    distance_next = range.distance_q4;
                    class_next    = range.proximity;
                end
            end
            default: err = ERR_INVALID;
        endcase

        res_next.accepted      = (err == ERR_NONE);
        res_next.error_code    = err;
        res_next.phase         = phase_next;
        res_next.trigger_level = trigger_next;
        res_next.echo_time     = time_next;
        res_next.distance_q4   = distance_next;
        res_next.proximity     = class_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_STOPPED;
            trigger_reg   <= 1'b0;
            time_reg      <= '0;
            distance_reg  <= '0;
            class_reg     <= CL_SAFE;
            res_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg    <= phase_next;
                trigger_reg  <= trigger_next;
                time_reg     <= time_next;
                distance_reg <= distance_next;
                class_reg    <= class_next;
            end
            if (advance) begin
                res_valid_reg <= 1'b1;
            end else if (res_taken) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/core/ultrasonic_range_sequencer.sv
// Top level of the ultrasonic range sequencer: input stage, handshakes, assertions.
// Depends on rus_pkg, rus_thresholds, rus_range_calc, rus_phase_fsm and the assert header.
`timescale 1ns / 1ps

// Each input beat is one event (opcode in s_tuser, echo count in s_tdata) and
// yields exactly one result beat. A beat is held in an input register and
// processed into the result register on the next edge that the result side
// can take. One event per cycle is sustained while m_tready stays high; the
// limit is the combinational path through the constant multiplies for distance
// and the threshold compares. While a finished result waits on m_tready, the
// input register takes one more beat and then s_tready stays low until the
// result beat is taken. Threshold writes on the cfg port are meant for idle
// periods only; a write is stored pre-scaled by 2000 and takes effect on the
// following event.
module ultrasonic_range_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes: index 0 warning_mm, index 1 danger_mm.
    input  logic                            cfg_wr_en,
    input  logic [rus_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rus_pkg::THR_W-1:0]       cfg_wdata,
    // Event channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rus_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] echo_count
    input  logic [rus_pkg::S_TUSER_W-1:0]   s_tuser,  // [2:0] opcode
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] accepted, [2:1] error_code, [4:3] phase, [5] trigger_level,
    // [21:6] echo_time, [39:22] distance_q4, [41:40] proximity, rest zero
    output logic [rus_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rus_pkg::*;

    `include "ultrasonic_range_sequencer_assert.svh"

    logic                in_valid_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic [ECHO_W-1:0]   echo_reg;
    logic                out_ready;
    logic                advance;
    thr_t                thr;
    range_t              range;
    result_t             res;

    assign out_ready = !m_tvalid || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            opcode_reg <= s_tuser;
            echo_reg   <= s_tdata[ECHO_W-1:0];
        end
    end

    rus_thresholds u_thresholds (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .thr       (thr)
    );

    rus_range_calc u_range_calc (
        .echo_count (echo_reg),
        .thr        (thr),
        .range      (range)
    );

    rus_phase_fsm u_phase_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .opcode    (opcode_reg),
        .range     (range),
        .res_taken (m_tready),
        .res_valid (m_tvalid),
        .res       (res)
    );

    assign m_tdata = {(M_TDATA_W - RESULT_W)'(0), res};

    // A result beat reports acceptance exactly when its error code is none.
    `RUS_ASSERT_SAME(a_accept_matches_err, m_tvalid, res.accepted == (res.error_code == ERR_NONE), "accepted flag disagrees with error code")
    // The trigger pin is only ever high in the triggering phase.
    `RUS_ASSERT_SAME(a_trigger_phase, m_tvalid && res.trigger_level, res.phase == PH_TRIGGER, "trigger high outside triggering phase")
    // A buffered event is never dropped while the result side is stalled.
    `RUS_ASSERT_NEXT(a_event_held, in_valid_reg && !out_ready, in_valid_reg && $stable(opcode_reg) && $stable(echo_reg), "buffered event lost during stall")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for ultrasonic_range_sequencer: directed event table, then random
// measurement sequences checked against an in-bench predictor across several threshold settings.
// Depends on rus_pkg and the RTL of the sequencer.
`timescale 1ns / 1ps

module tb_top;
    import rus_pkg::*;

    // Opcodes that the block must reject as unknown.
    localparam logic [OPCODE_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD7 = 3'd7;

    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam logic [THR_W-1:0] THR_TOP = '1;

    typedef enum int {RX_FULL, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [ECHO_W-1:0]   count;
        bit                  typed;
        result_t             want;
    } event_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [THR_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Predicted state of the sequencer and its thresholds.
    logic [PHASE_W-1:0] ph_q;
    logic               trig_q;
    logic [TIME_W-1:0]  time_q;
    logic [DIST_W-1:0]  dist_q;
    logic [CLASS_W-1:0] prox_q;
    logic [THR_W-1:0]   warn_thr;
    logic [THR_W-1:0]   dang_thr;

    result_t    range_results[$];
    event_row_t event_table[$];
    int         error_count = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    bit         hold_req    = 1'b0;
    result_t    seen;
    result_t    oldest;

    ultrasonic_range_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic result_t range_event(input logic [OPCODE_W-1:0] op,
                                            input logic [ECHO_W-1:0] count);
        result_t         r;
        logic [ERR_W-1:0] err;
        longint unsigned c;
        longint unsigned scaled;
        longint unsigned d;
        err    = ERR_NONE;
        c      = longint'(count) & ((64'd1 << COUNT_WIDTH) - 1);
        scaled = c * 343;
        d      = scaled / 125;
        case (op)
            OP_ENABLE: begin
                if (ph_q != PH_STOPPED) err = ERR_BUSY;
                else ph_q = PH_WAITING;
            end
            OP_START: begin
                if (ph_q != PH_WAITING) err = ERR_INVALID;
                else begin
                    ph_q   = PH_TRIGGER;
                    trig_q = 1'b1;
                end
            end
            OP_TRIG_OFF: begin
                if (ph_q != PH_TRIGGER) err = ERR_INVALID;
                else begin
                    ph_q   = PH_RUNNING;
                    trig_q = 1'b0;
                end
            end
            OP_OVERFLOW: begin
                if (ph_q != PH_RUNNING) err = ERR_INVALID;
                else begin
                    ph_q   = PH_STOPPED;
                    trig_q = 1'b0;
                    time_q = TIME_MAX;
                    dist_q = DIST_MAX;
                end
            end
            OP_ECHO: begin
                if (ph_q != PH_RUNNING) err = ERR_INVALID;
                else begin
                    ph_q   = PH_STOPPED;
                    trig_q = 1'b0;
                    time_q = (c > longint'(TIME_MAX)) ? TIME_MAX : c[TIME_W-1:0];
                    dist_q = (d > longint'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
                    // Danger is tested first, so out-of-order thresholds favor danger.
                    if (scaled <= longint'(dang_thr) * 2000) prox_q = CL_DANGER;
                    else if (scaled <= longint'(warn_thr) * 2000) prox_q = CL_WARNING;
                    else prox_q = CL_SAFE;
                end
            end
            default: err = ERR_INVALID;
        endcase
        r.accepted      = (err == ERR_NONE);
        r.error_code    = err;
        r.phase         = ph_q;
        r.trigger_level = trig_q;
        r.echo_time     = time_q;
        r.distance_q4   = dist_q;
        r.proximity     = prox_q;
        return r;
    endfunction

    function automatic event_row_t typed_row(input logic [OPCODE_W-1:0] op,
                                             input logic [ECHO_W-1:0] count,
                                             input logic acc, input logic [ERR_W-1:0] err,
                                             input logic [PHASE_W-1:0] ph, input logic trig,
                                             input logic [TIME_W-1:0] tm,
                                             input logic [DIST_W-1:0] distance,
                                             input logic [CLASS_W-1:0] prox);
        event_row_t row;
        row.op                 = op;
        row.count              = count;
        row.typed              = 1'b1;
        row.want.accepted      = acc;
        row.want.error_code    = err;
        row.want.phase         = ph;
        row.want.trigger_level = trig;
        row.want.echo_time     = tm;
        row.want.distance_q4   = distance;
        row.want.proximity     = prox;
        return row;
    endfunction

    function automatic event_row_t open_row(input logic [OPCODE_W-1:0] op,
                                            input logic [ECHO_W-1:0] count);
        event_row_t row;
        row.op    = op;
        row.count = count;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Counts near the class boundaries of the current thresholds, or anywhere.
    function automatic logic [ECHO_W-1:0] pick_count();
        int unsigned bound;
        case ($urandom_range(0, 3))
            0: bound = dang_thr * 2000 / 343;
            1: bound = warn_thr * 2000 / 343;
            default: return ECHO_W'($urandom);
        endcase
        bound = bound + $urandom_range(0, 6);
        bound = (bound > 3) ? bound - 3 : 0;
        if (bound > 65535) bound = 65535;
        return bound[ECHO_W-1:0];
    endfunction

    // Offers one event beat, in bursts with random gaps, and records its outcome once taken.
    task automatic send_event(input logic [OPCODE_W-1:0] op, input logic [ECHO_W-1:0] count,
                              input bit typed, input result_t typed_want);
        int      gap;
        result_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= count;
        do @(posedge aclk); while (!s_tready);
        predicted = range_event(op, count);
        range_results.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (range_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_thresholds(input logic [THR_W-1:0] warn, input logic [THR_W-1:0] dang);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_WARNING;
        cfg_wdata <= warn;
        @(posedge aclk);
        cfg_addr  <= REG_DANGER;
        cfg_wdata <= dang;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        warn_thr = warn;
        dang_thr = dang;
    endtask

    // Mostly complete measurement sequences, with stray and unknown events mixed in.
    task automatic run_random(input int n);
        logic [OPCODE_W-1:0] op;
        logic [ECHO_W-1:0]   count;
        for (int i = 0; i < n; i++) begin
            count = ECHO_W'($urandom);
            if ($urandom_range(0, 9) < 2) begin
                op = OPCODE_W'($urandom_range(0, 7));
            end else begin
                case (ph_q)
                    PH_STOPPED: op = OP_ENABLE;
                    PH_WAITING: op = OP_START;
                    PH_TRIGGER: op = OP_TRIG_OFF;
                    default:    op = ($urandom_range(0, 7) == 0) ? OP_OVERFLOW : OP_ECHO;
                endcase
            end
            if (op == OP_ECHO && $urandom_range(0, 3) != 0) count = pick_count();
            send_event(op, count, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[RESULT_W-1:0];
            if (range_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, m_tdata);
                error_count++;
            end else begin
                oldest = range_results.pop_front();
                check_field("accepted", oldest.accepted, seen.accepted);
                check_field("error_code", oldest.error_code, seen.error_code);
                check_field("phase", oldest.phase, seen.phase);
                check_field("trigger_level", oldest.trigger_level, seen.trigger_level);
                check_field("echo_time", oldest.echo_time, seen.echo_time);
                check_field("distance_q4", oldest.distance_q4, seen.distance_q4);
                check_field("proximity", oldest.proximity, seen.proximity);
                check_field("padding", 0, m_tdata[M_TDATA_W-1:RESULT_W]);
            end
        end
    end

    // Result side: changing stall patterns, plus a long hold-off when requested.
    initial begin
        rx_mode_t mode;
        int       mode_left;
        mode      = RX_FULL;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_FULL:   m_tready <= 1'b1;
                    RX_HALF:   m_tready <= $urandom_range(0, 1);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        ph_q     = PH_STOPPED;
        trig_q   = 1'b0;
        time_q   = '0;
        dist_q   = '0;
        prox_q   = CL_SAFE;
        warn_thr = WARNING_RESET;
        dang_thr = DANGER_RESET;

        event_table = '{
            // Everything but enable is rejected while stopped; reset state is reported.
            typed_row(OP_ECHO, 16'hFFFF, 1'b0, ERR_INVALID, PH_STOPPED, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_START, 16'h0000, 1'b0, ERR_INVALID, PH_STOPPED, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_TRIG_OFF, 16'h5A5A, 1'b0, ERR_INVALID, PH_STOPPED, 1'b0, 0, 0,
                      CL_SAFE),
            typed_row(OP_OVERFLOW, 16'hA5A5, 1'b0, ERR_INVALID, PH_STOPPED, 1'b0, 0, 0,
                      CL_SAFE),
            typed_row(OP_RSVD5, 16'h0001, 1'b0, ERR_INVALID, PH_STOPPED, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_RSVD7, 16'h8000, 1'b0, ERR_INVALID, PH_STOPPED, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_ENABLE, 16'h0000, 1'b1, ERR_NONE, PH_WAITING, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_ENABLE, 16'h0000, 1'b0, ERR_BUSY, PH_WAITING, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_ECHO, 16'h0001, 1'b0, ERR_INVALID, PH_WAITING, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_START, 16'h0000, 1'b1, ERR_NONE, PH_TRIGGER, 1'b1, 0, 0, CL_SAFE),
            typed_row(OP_ENABLE, 16'h0000, 1'b0, ERR_BUSY, PH_TRIGGER, 1'b1, 0, 0, CL_SAFE),
            typed_row(OP_OVERFLOW, 16'h0000, 1'b0, ERR_INVALID, PH_TRIGGER, 1'b1, 0, 0,
                      CL_SAFE),
            typed_row(OP_TRIG_OFF, 16'h0000, 1'b1, ERR_NONE, PH_RUNNING, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_ENABLE, 16'h0000, 1'b0, ERR_BUSY, PH_RUNNING, 1'b0, 0, 0, CL_SAFE),
            typed_row(OP_START, 16'h0000, 1'b0, ERR_INVALID, PH_RUNNING, 1'b0, 0, 0, CL_SAFE),
            // A zero count is always within the danger threshold.
            typed_row(OP_ECHO, 16'h0000, 1'b1, ERR_NONE, PH_STOPPED, 1'b0, 0, 0, CL_DANGER),
            open_row(OP_ENABLE, 16'h0000),
            open_row(OP_START, 16'h0000),
            open_row(OP_TRIG_OFF, 16'h0000),
            // Overflow saturates time and distance and keeps the class.
            typed_row(OP_OVERFLOW, 16'hFFFF, 1'b1, ERR_NONE, PH_STOPPED, 1'b0, TIME_MAX,
                      DIST_MAX, CL_DANGER),
            open_row(OP_ENABLE, 16'h0000),
            open_row(OP_START, 16'h0000),
            open_row(OP_TRIG_OFF, 16'h0000),
            open_row(OP_ECHO, 16'hFFFF)
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (event_table[i]) begin
            send_event(event_table[i].op, event_table[i].count, event_table[i].typed,
                       event_table[i].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0: ;
                1: set_thresholds('0, '0);
                2: set_thresholds(THR_TOP, THR_TOP);
                3: set_thresholds(THR_TOP, '0);
                4: set_thresholds('0, THR_TOP);
                7: set_thresholds(WARNING_RESET, DANGER_RESET);
                default: set_thresholds(THR_W'($urandom_range(0, 3000)),
                                        THR_W'($urandom_range(0, 3000)));
            endcase
            // Back up the whole block a couple of times while the sender keeps offering.
            if (p == 2 || p == 5) hold_req = 1'b1;
            run_random(ITEMS_PER_PHASE);
        end

        drain();
        repeat (5) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rus_pkg.sv
rtl/core/rus_thresholds.sv
rtl/core/rus_range_calc.sv
rtl/core/rus_phase_fsm.sv
rtl/core/ultrasonic_range_sequencer.sv
verif/tb_top.sv
